// ===== rtl/xks_pkg.sv =====
// shared types, constants and generator functions for the xorshift keystream byte cipher
package xks_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;

  localparam logic [WordW-1:0] MultK = 32'h001d_a597;
  localparam logic [WordW-1:0] AddK2 = 32'h0085_c9c2;
  localparam logic [WordW-1:0] AddK3 = 32'h010b_9384;
  localparam logic [WordW-1:0] AddK4 = 32'h0191_5d46;
  localparam int unsigned ShlA = 11;
  localparam int unsigned ShrD = 19;

  // register indexes on the configuration port
  localparam logic RegKeyWord = 1'b0;

  // input beat kinds carried on tuser
  localparam logic CmdData   = 1'b0;
  localparam logic CmdReseed = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEED
  } xks_state_t;

  typedef struct packed {
    logic       seed_start;
    logic       seed_en;
    logic [1:0] seed_step;
    logic       byte_en;
  } xks_cmd_t;

  typedef struct packed {
    logic out_full;
  } xks_status_t;

  // additive term of each seeding step
  function automatic logic [WordW-1:0] seed_add(input logic [1:0] step);
    logic [WordW-1:0] k;
    unique case (step)
      2'd0:    k = '0;
      2'd1:    k = AddK2;
      2'd2:    k = AddK3;
      default: k = AddK4;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/xks_ctrl.sv =====
// controller state machine: beat acceptance and reseed sequencing
module xks_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tuser,
  input  logic               out_tready,
  input  xks_pkg::xks_status_t status,
  output logic               in_tready,
  output xks_pkg::xks_cmd_t    cmd
);

  xks_pkg::xks_state_t state_r, state_nxt;
  logic [1:0]          step_r, step_nxt;
  logic                accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xks_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    in_tready      = 1'b0;
    accept         = 1'b0;
    cmd.seed_start = 1'b0;
    cmd.seed_en    = 1'b0;
    cmd.seed_step  = step_r;
    cmd.byte_en    = 1'b0;
    unique case (state_r)
      xks_pkg::ST_IDLE: begin
        in_tready = !status.out_full || out_tready;
        accept    = in_tready && in_tvalid;
        if (accept) begin
          if (in_tuser == xks_pkg::CmdReseed) begin
            cmd.seed_start = 1'b1;
            state_nxt      = xks_pkg::ST_SEED;
            step_nxt       = '0;
          end else begin
            cmd.byte_en = 1'b1;
          end
        end
      end
      xks_pkg::ST_SEED: begin
        cmd.seed_en = 1'b1;
        step_nxt    = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = xks_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = xks_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/xks_dp.sv =====
// datapath: generator words, seeding multiplier, keystream roll and output register
module xks_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  xks_pkg::xks_cmd_t           cmd,
  input  logic [xks_pkg::WordW-1:0]   key_word,
  input  logic [xks_pkg::ByteW-1:0]   in_data,
  input  logic                        in_last,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [xks_pkg::ByteW-1:0]   out_tdata,
  output xks_pkg::xks_status_t        status
);

  logic [xks_pkg::WordW-1:0] gen_r [4];
  logic [xks_pkg::WordW-1:0] gen_nxt [4];
  logic [xks_pkg::WordW-1:0] held_r, held_nxt;
  logic [1:0]                slot_r, slot_nxt;
  logic                      roll_r, roll_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [xks_pkg::ByteW-1:0] out_data_r, out_data_nxt;

  logic [xks_pkg::WordW-1:0] seed_src, seed_prod, seed_word;
  logic [xks_pkg::WordW-1:0] t_word, mid_word, fin_word, ks_word;
  logic [1:0]                slot_use, slot_inc;
  logic [xks_pkg::ByteW-1:0] ks_byte;

  // seeding step: one 32x32 truncated multiply by the constant
  always_comb begin
    unique case (cmd.seed_step)
      2'd0:    seed_src = key_word;
      2'd1:    seed_src = gen_r[0];
      2'd2:    seed_src = gen_r[1];
      default: seed_src = gen_r[2];
    endcase
    seed_prod = xks_pkg::WordW'(seed_src * xks_pkg::MultK);
    seed_word = seed_prod ^ ((seed_src >> 5) + xks_pkg::seed_add(cmd.seed_step));
  end

  // xorshift128 roll
  always_comb begin
    t_word   = gen_r[0] ^ (gen_r[0] << xks_pkg::ShlA);
    mid_word = gen_r[3] ^ t_word ^ (t_word >> 8);
    fin_word = mid_word ^ (gen_r[3] >> xks_pkg::ShrD);
    ks_word  = roll_r ? {mid_word[31:16], fin_word[15:0]} : held_r;
    slot_use = roll_r ? 2'd0 : slot_r;
    unique case (slot_use)
      2'd0:    ks_byte = ks_word[31:24];
      2'd1:    ks_byte = ks_word[23:16];
      2'd2:    ks_byte = ks_word[15:8];
      default: ks_byte = ks_word[7:0];
    endcase
    slot_inc = slot_use + 2'd1;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      gen_nxt[i] = gen_r[i];
    end
    held_nxt      = held_r;
    slot_nxt      = slot_r;
    roll_nxt      = roll_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.seed_start) begin
      slot_nxt = '0;
      roll_nxt = 1'b1;
    end
    if (cmd.seed_en) begin
      gen_nxt[cmd.seed_step] = seed_word;
    end
    if (cmd.byte_en) begin
      if (roll_r) begin
        gen_nxt[0] = gen_r[1];
        gen_nxt[1] = gen_r[2];
        gen_nxt[2] = gen_r[3];
        gen_nxt[3] = fin_word;
        held_nxt   = ks_word;
      end
      out_data_nxt  = in_data ^ ks_byte;
      out_valid_nxt = 1'b1;
      if (in_last || slot_inc == 2'd0) begin
        slot_nxt = '0;
        roll_nxt = 1'b1;
      end else begin
        slot_nxt = slot_inc;
        roll_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        gen_r[i] <= '0;
      end
      held_r      <= '0;
      slot_r      <= '0;
      roll_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        gen_r[i] <= gen_nxt[i];
      end
      held_r      <= held_nxt;
      slot_r      <= slot_nxt;
      roll_r      <= roll_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign status.out_full = out_valid_r;

endmodule

// ===== rtl/xorshift_keystream_byte_cipher.sv =====
// top level of the xorshift keystream byte cipher: config register, controller and datapath
// data beat: result in the next cycle, one beat per cycle while out_tready is high
// reseed beat: no result, input held off while the shared multiplier
//   derives the four generator words one per cycle
// every fourth byte (or first byte after end of buffer/reseed) rolls the generator in-line
// synchronous active-low reset clears generator words, keystream hold, slot and key register
module xorshift_keystream_byte_cipher (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] cmd (0 data byte, 1 reseed)
  input  logic        in_tlast,   // end_of_buffer
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  xks_pkg::xks_cmd_t    cmd;
  xks_pkg::xks_status_t status;

  logic [xks_pkg::WordW-1:0] key_r, key_nxt;
  logic                      cfg_wr;
  logic                      cfg_hit;

  // register file: key word at byte address 0
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == xks_pkg::RegKeyWord);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? key_r : '0;

  always_comb begin
    key_nxt = key_r;
    if (cfg_wr && cfg_hit) begin
      key_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // controller decides when a beat is taken and sequences the reseed
  xks_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .status     (status),
    .in_tready  (in_tready),
    .cmd        (cmd)
  );

  // datapath holds generator state and the output register
  xks_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .key_word   (key_r),
    .in_data    (in_tdata),
    .in_last    (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .status     (status)
  );

  // no beat taken while the reseed sequence runs
  a_seed_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seed_en |-> !in_tready)
    else $error("input accepted during reseed");

  // a data beat always produces a result in the next cycle
  a_data_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == xks_pkg::CmdData) |=> out_tvalid)
    else $error("data beat lost");

  // a reseed beat starts the sequence at step zero
  a_reseed_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == xks_pkg::CmdReseed) |=>
      (cmd.seed_en && cmd.seed_step == 2'd0))
    else $error("reseed did not start");

  // a stalled result holds off new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted over a stalled result");

endmodule
